// File: src/mtlca_pkg.sv
// Shared types and codes for the merge tree common-ancestor engine.
package mtlca_pkg;

  typedef enum logic [1:0] {
    CMD_MERGE = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_F_RD,
    ST_F_CHK,
    ST_C_RD,
    ST_C_WR,
    ST_M_W1,
    ST_M_W2,
    ST_B_INIT,
    ST_B_RDI,
    ST_B_GOTI,
    ST_B_LVL,
    ST_B_WR,
    ST_Q_D1,
    ST_Q_D2,
    ST_Q_D3,
    ST_L1_RU,
    ST_L1_RA,
    ST_L1_CMP,
    ST_L2_RU,
    ST_L2_RV,
    ST_L2_CMP,
    ST_Q_R0,
    ST_Q_END,
    ST_DONE
  } state_e;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_REJ = 1'b1;

  // Reset value of the leaf count register.
  localparam int LeafReset = 512;

endpackage

// File: src/mtlca_store.sv
// Node stores: union-find parents, node depths and ancestor rows, registered reads.
module mtlca_store #(
  parameter int MAX_NODES   = 1024,
  parameter int JUMP_LEVELS = 10,
  localparam int NW = $clog2(MAX_NODES),
  localparam int RW = JUMP_LEVELS * NW
) (
  input  logic          clk_i,
  input  logic [NW-1:0] sp_raddr_i,
  input  logic          sp_we_i,
  input  logic [NW-1:0] sp_waddr_i,
  input  logic [NW-1:0] sp_wdata_i,
  output logic [NW-1:0] sp_rdata_o,
  input  logic [NW-1:0] dep_raddr_i,
  input  logic          dep_we_i,
  input  logic [NW-1:0] dep_waddr_i,
  input  logic [NW-1:0] dep_wdata_i,
  output logic [NW-1:0] dep_rdata_o,
  input  logic [NW-1:0] anc_raddr_i,
  input  logic          anc_we_i,
  input  logic [NW-1:0] anc_waddr_i,
  input  logic [RW-1:0] anc_wdata_i,
  output logic [RW-1:0] anc_rdata_o
);

  logic [NW-1:0] sp_mem  [MAX_NODES];
  logic [NW-1:0] dep_mem [MAX_NODES];
  logic [RW-1:0] anc_mem [MAX_NODES];

  always_ff @(posedge clk_i) begin
    if (sp_we_i) begin
      sp_mem[sp_waddr_i] <= sp_wdata_i;
    end
    sp_rdata_o <= sp_mem[sp_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (dep_we_i) begin
      dep_mem[dep_waddr_i] <= dep_wdata_i;
    end
    dep_rdata_o <= dep_mem[dep_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (anc_we_i) begin
      anc_mem[anc_waddr_i] <= anc_wdata_i;
    end
    anc_rdata_o <= anc_mem[anc_raddr_i];
  end

endmodule

// File: src/merge_tree_lca_engine_core.sv
// Top level: sequencer of the merge tree common-ancestor engine.
//
//  Channel   | Direction | Handshake                 | Contents
//  ----------+-----------+---------------------------+-------------------------------------
//  s_axis    | in        | s_axis_tvalid/tready      | tdata: node_a, node_b; tuser: command
//  m_axis    | out       | m_axis_tvalid/tready      | tdata: result_node; tuser: status
//  cfg       | in        | cfg_valid_i/cfg_ready_o   | cfg_data_i: leaf_count
//
// One command at a time through a single sequencer and one read port per store.
// Reset and every leaf count write start a clearing sweep over all MAX_NODES entries of the
//   parent and ancestor stores; no command transfer is taken meanwhile.
// A finished result waits in the output register; the next command is taken meanwhile
//   and only its completion stalls on the output.
module merge_tree_lca_engine_core
  import mtlca_pkg::*;
#(
  parameter int MAX_NODES   = 1024,
  parameter int JUMP_LEVELS = 10,
  localparam int NW    = $clog2(MAX_NODES),
  localparam int KW    = $clog2(JUMP_LEVELS),
  localparam int IN_W  = ((2 * NW + 7) / 8) * 8,
  localparam int OUT_W = ((NW + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // node_a, node_b, zero pad
  input  logic [1:0]       s_axis_tuser,   // command
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // result_node, zero pad
  output logic             m_axis_tuser,   // status
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [NW-1:0]    cfg_data_i      // leaf_count
);

  localparam logic [NW-1:0] NodeMax = NW'(MAX_NODES - 1);
  localparam logic [NW-1:0] LeafRst =
    (LeafReset > MAX_NODES - 1) ? NW'(MAX_NODES - 1) : NW'(LeafReset);
  localparam logic [KW-1:0] KTop = KW'(JUMP_LEVELS - 1);

  typedef logic [JUMP_LEVELS-1:0][NW-1:0] row_t;

  state_e state_q, state_d;

  logic [NW-1:0] cnt_q, cnt_d;       // node counter
  logic          built_q, built_d;
  logic [NW-1:0] i_q, i_d;           // sweep and build index
  logic [NW-1:0] r_q, r_d;           // root walk head
  logic [NW-1:0] x_q, x_d;           // compression walk
  logic [NW-1:0] ra_q, ra_d;
  logic          side_q, side_d;
  logic [NW-1:0] u_q, u_d, v_q, v_d;
  logic [NW-1:0] du_q, du_d, dv_q, dv_d;
  logic [NW-1:0] a_q, a_d;
  logic [KW-1:0] k_q, k_d;
  row_t          row_q, row_d;
  logic [NW-1:0] res_q, res_d;
  logic          st_q, st_d;
  logic          ov_q, ov_d;
  logic [NW-1:0] onode_q, onode_d;
  logic          ost_q, ost_d;
  logic [NW-1:0] b_hold_q, b_hold_d; // second merge operand

  // Store ports
  logic [NW-1:0] sp_raddr, sp_waddr, sp_wdata, sp_rdata;
  logic          sp_we;
  logic [NW-1:0] dep_raddr, dep_waddr, dep_wdata, dep_rdata;
  logic          dep_we;
  logic [NW-1:0] anc_raddr, anc_waddr;
  logic          anc_we;
  row_t          anc_wdata, anc_rdata;

  logic          in_xfer, cfg_xfer;
  cmd_e          cmd;
  logic [NW-1:0] in_a, in_b;
  logic          in_range;
  logic [NW-1:0] cfg_eff;
  logic [KW-1:0] km1;
  logic [NW-1:0] nn;
  logic [NW-1:0] u_nx;
  logic          out_free;

  assign in_xfer  = s_axis_tvalid & s_axis_tready;
  assign cfg_xfer = cfg_valid_i & cfg_ready_o;
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);

  assign cmd  = cmd_e'(s_axis_tuser);
  assign in_a = s_axis_tdata[NW-1:0];
  assign in_b = s_axis_tdata[2*NW-1:NW];
  assign in_range = (in_a != '0) && (in_a <= cnt_q) && (in_b != '0) && (in_b <= cnt_q);

  // Hold the second operand from the accepted command.
  assign b_hold_d = in_xfer ? in_b : b_hold_q;

  // Raise a zero leaf count to one node and cap it at NodeMax, which leaves a full store.
  assign cfg_eff = (cfg_data_i == '0) ? NW'(1) :
                   (cfg_data_i > NodeMax) ? NodeMax : cfg_data_i;

  assign km1 = k_q - KW'(1);
  assign nn  = cnt_q + NW'(1);
  assign out_free = ~ov_q | m_axis_tready;

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = OUT_W'(onode_q);
  assign m_axis_tuser  = ost_q;

  // Next state and datapath
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    built_d = built_q;
    i_d     = i_q;
    r_d     = r_q;
    x_d     = x_q;
    ra_d    = ra_q;
    side_d  = side_q;
    u_d     = u_q;
    v_d     = v_q;
    du_d    = du_q;
    dv_d    = dv_q;
    a_d     = a_q;
    k_d     = k_q;
    row_d   = row_q;
    res_d   = res_q;
    st_d    = st_q;
    onode_d = onode_q;
    ost_d   = ost_q;
    ov_d    = ov_q & ~m_axis_tready;
    u_nx    = u_q;

    unique case (state_q)
      ST_CLEAR: begin
        i_d = i_q + NW'(1);
        if (i_q == NodeMax) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          res_d = '0;
          st_d  = STATUS_REJ;
          state_d = ST_DONE;
          unique case (cmd)
            CMD_MERGE: begin
              if (!built_q && in_range && cnt_q < NodeMax) begin
                r_d = in_a;
                x_d = in_a;
                side_d = 1'b0;
                state_d = ST_F_RD;
              end
            end
            CMD_BUILD: begin
              state_d = ST_B_INIT;
            end
            CMD_QUERY: begin
              if (built_q && in_range) begin
                u_d = in_a;
                v_d = in_b;
                state_d = ST_Q_D1;
              end
            end
            default: ;
          endcase
        end
      end
      // Root walk: advance along set parents until a node points to itself.
      ST_F_RD: state_d = ST_F_CHK;
      ST_F_CHK: begin
        if (sp_rdata == r_q) begin
          state_d = ST_C_RD;
        end else begin
          r_d = sp_rdata;
        end
      end
      // Compression walk: point every node on the path at the root.
      ST_C_RD: begin
        if (x_q == r_q) begin
          if (!side_q) begin
            ra_d   = r_q;
            side_d = 1'b1;
            r_d    = b_hold_q;
            x_d    = b_hold_q;
            state_d = ST_F_RD;
          end else begin
            state_d = ST_M_W1;
          end
        end else begin
          state_d = ST_C_WR;
        end
      end
      ST_C_WR: begin
        x_d = sp_rdata;
        state_d = ST_C_RD;
      end
      ST_M_W1: state_d = ST_M_W2;
      ST_M_W2: begin
        cnt_d = nn;
        res_d = nn;
        st_d  = STATUS_OK;
        state_d = ST_DONE;
      end
      // Build: walk nodes downward; ancestors always carry higher numbers.
      ST_B_INIT: begin
        i_d = cnt_q;
        state_d = ST_B_RDI;
      end
      ST_B_RDI: state_d = ST_B_GOTI;
      ST_B_GOTI: begin
        row_d = anc_rdata;
        k_d   = KW'(1);
        state_d = ST_B_LVL;
      end
      ST_B_LVL: begin
        row_d[k_q] = anc_rdata[km1];
        if (k_q == KTop) begin
          state_d = ST_B_WR;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      ST_B_WR: begin
        if (i_q == NW'(1)) begin
          built_d = 1'b1;
          res_d = '0;
          st_d  = STATUS_OK;
          state_d = ST_DONE;
        end else begin
          i_d = i_q - NW'(1);
          state_d = ST_B_RDI;
        end
      end
      // Query: fetch both depths, keep the deeper node in u.
      ST_Q_D1: state_d = ST_Q_D2;
      ST_Q_D2: begin
        du_d = dep_rdata;
        state_d = ST_Q_D3;
      end
      ST_Q_D3: begin
        if (du_q < dep_rdata) begin
          u_d  = v_q;
          v_d  = u_q;
          dv_d = du_q;
        end else begin
          dv_d = dep_rdata;
        end
        k_d = KTop;
        state_d = ST_L1_RU;
      end
      ST_L1_RU: state_d = ST_L1_RA;
      ST_L1_RA: begin
        a_d = anc_rdata[k_q];
        state_d = ST_L1_CMP;
      end
      ST_L1_CMP: begin
        if (a_q != '0 && dep_rdata >= dv_q) begin
          u_nx = a_q;
        end
        u_d = u_nx;
        if (k_q == '0) begin
          if (u_nx == v_q) begin
            res_d = u_nx;
            st_d  = STATUS_OK;
            state_d = ST_DONE;
          end else begin
            k_d = KTop;
            state_d = ST_L2_RU;
          end
        end else begin
          k_d = km1;
          state_d = ST_L1_RU;
        end
      end
      ST_L2_RU: state_d = ST_L2_RV;
      ST_L2_RV: begin
        a_d = anc_rdata[k_q];
        state_d = ST_L2_CMP;
      end
      ST_L2_CMP: begin
        if (a_q != '0 && anc_rdata[k_q] != '0 && a_q != anc_rdata[k_q]) begin
          u_d = a_q;
          v_d = anc_rdata[k_q];
        end
        if (k_q == '0) begin
          state_d = ST_Q_R0;
        end else begin
          k_d = km1;
          state_d = ST_L2_RU;
        end
      end
      ST_Q_R0: state_d = ST_Q_END;
      ST_Q_END: begin
        res_d = anc_rdata[0];
        st_d  = STATUS_OK;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          ov_d    = 1'b1;
          onode_d = res_q;
          ost_d   = st_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // A leaf count write restarts the block from a clean store.
    if (cfg_xfer) begin
      cnt_d   = cfg_eff;
      built_d = 1'b0;
      i_d     = '0;
      state_d = ST_CLEAR;
    end
  end

  // Store control
  always_comb begin
    sp_raddr  = r_q;
    sp_we     = 1'b0;
    sp_waddr  = x_q;
    sp_wdata  = r_q;
    dep_raddr = u_q;
    dep_we    = 1'b0;
    dep_waddr = i_q;
    dep_wdata = dep_rdata + NW'(1);
    anc_raddr = u_q;
    anc_we    = 1'b0;
    anc_waddr = i_q;
    anc_wdata = row_q;

    unique case (state_q)
      ST_CLEAR: begin
        sp_we     = 1'b1;
        sp_waddr  = i_q;
        sp_wdata  = i_q;
        anc_we    = 1'b1;
        anc_wdata = '0;
      end
      ST_F_CHK: sp_raddr = sp_rdata;
      ST_C_RD:  sp_raddr = x_q;
      ST_C_WR:  sp_we    = 1'b1;
      ST_M_W1: begin
        sp_we     = 1'b1;
        sp_waddr  = ra_q;
        sp_wdata  = nn;
        anc_we    = 1'b1;
        anc_waddr = ra_q;
        anc_wdata = '0;
        anc_wdata[0] = nn;
      end
      ST_M_W2: begin
        sp_we     = 1'b1;
        sp_waddr  = r_q;
        sp_wdata  = nn;
        anc_we    = 1'b1;
        anc_waddr = r_q;
        anc_wdata = '0;
        anc_wdata[0] = nn;
      end
      ST_B_INIT: begin
        dep_we    = 1'b1;
        dep_waddr = '0;
        dep_wdata = '0;
      end
      ST_B_RDI: anc_raddr = i_q;
      ST_B_GOTI: begin
        anc_raddr = anc_rdata[0];
        dep_raddr = anc_rdata[0];
      end
      ST_B_LVL: begin
        anc_raddr = anc_rdata[km1];
        dep_we    = (k_q == KW'(1));
      end
      ST_B_WR:  anc_we = 1'b1;
      ST_Q_D1:  dep_raddr = u_q;
      ST_Q_D2:  dep_raddr = v_q;
      ST_L1_RU: anc_raddr = u_q;
      ST_L1_RA: dep_raddr = anc_rdata[k_q];
      ST_L2_RU: anc_raddr = u_q;
      ST_L2_RV: anc_raddr = v_q;
      ST_Q_R0:  anc_raddr = u_q;
      default: ;
    endcase
  end

  mtlca_store #(
    .MAX_NODES  (MAX_NODES),
    .JUMP_LEVELS(JUMP_LEVELS)
  ) u_store (
    .clk_i      (clk_i),
    .sp_raddr_i (sp_raddr),
    .sp_we_i    (sp_we),
    .sp_waddr_i (sp_waddr),
    .sp_wdata_i (sp_wdata),
    .sp_rdata_o (sp_rdata),
    .dep_raddr_i(dep_raddr),
    .dep_we_i   (dep_we),
    .dep_waddr_i(dep_waddr),
    .dep_wdata_i(dep_wdata),
    .dep_rdata_o(dep_rdata),
    .anc_raddr_i(anc_raddr),
    .anc_we_i   (anc_we),
    .anc_waddr_i(anc_waddr),
    .anc_wdata_i(anc_wdata),
    .anc_rdata_o(anc_rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= LeafRst;
      built_q <= 1'b0;
      i_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      built_q <= built_d;
      i_q     <= i_d;
      ov_q    <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    r_q      <= r_d;
    x_q      <= x_d;
    ra_q     <= ra_d;
    side_q   <= side_d;
    u_q      <= u_d;
    v_q      <= v_d;
    du_q     <= du_d;
    dv_q     <= dv_d;
    a_q      <= a_d;
    k_q      <= k_d;
    row_q    <= row_d;
    res_q    <= res_d;
    st_q     <= st_d;
    onode_q  <= onode_d;
    ost_q    <= ost_d;
    b_hold_q <= b_hold_d;
  end

endmodule

// File: tb/merge_tree_lca_engine_core_tb.sv
// Self-checking testbench for the merge tree common-ancestor engine.
`timescale 1ns / 100ps

module merge_tree_lca_engine_core_tb;
  import mtlca_pkg::*;

  localparam int MaxNodes   = 1024;
  localparam int JumpLevels = 10;

  typedef struct {
    logic [9:0] node;
    logic       status;
  } answer_t;

  typedef struct {
    cmd_e       cmd;
    int         a;
    int         b;
    bit         known;
    int         node;
    logic       status;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;    // node_a, node_b, zero pad
  logic [1:0]  s_axis_tuser = CMD_NONE;  // command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // result_node, zero pad
  logic        m_axis_tuser;         // status
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [9:0]  cfg_data_i = '0;      // leaf_count

  merge_tree_lca_engine_core u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

  // Mirror of the engine state.
  int  jump_tab [JumpLevels][MaxNodes];
  int  set_up [MaxNodes];
  int  depth_of [MaxNodes];
  int  node_cnt;
  bit  tables_built;

  answer_t pending_answers[$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_cycles = 0;
  int  hold_left = 0;
  int  items_sent = 0;

  task automatic report(string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic void clear_model(int leaves);
    for (int k = 0; k < JumpLevels; k++)
      for (int i = 0; i < MaxNodes; i++) jump_tab[k][i] = 0;
    for (int i = 0; i < MaxNodes; i++) begin
      set_up[i] = i;
      depth_of[i] = 0;
    end
    node_cnt = (leaves == 0) ? 1 : (leaves > MaxNodes - 1 ? MaxNodes - 1 : leaves);
    tables_built = 1'b0;
  endfunction

  // Union-find root with path compression.
  function automatic int find_root(int x);
    int r;
    int nxt;
    r = x;
    while (set_up[r] != r) r = set_up[r];
    while (x != r) begin
      nxt = set_up[x];
      set_up[x] = r;
      x = nxt;
    end
    return r;
  endfunction

  function automatic int lowest_common(int u, int v);
    int t;
    int a;
    int b;
    if (depth_of[u] < depth_of[v]) begin
      t = u; u = v; v = t;
    end
    for (int k = JumpLevels - 1; k >= 0; k--) begin
      a = jump_tab[k][u];
      if (a != 0 && depth_of[a] >= depth_of[v]) u = a;
    end
    if (u == v) return u;
    for (int k = JumpLevels - 1; k >= 0; k--) begin
      a = jump_tab[k][u];
      b = jump_tab[k][v];
      if (a != 0 && b != 0 && a != b) begin
        u = a; v = b;
      end
    end
    return jump_tab[0][u];
  endfunction

  // Advance the mirror by one command and return the answer it gives.
  function automatic answer_t apply_command(cmd_e cmd, int a, int b);
    answer_t ans;
    bit      in_range;
    int      ra;
    int      rb;
    ans.node = '0;
    ans.status = STATUS_REJ;
    in_range = a >= 1 && a <= node_cnt && b >= 1 && b <= node_cnt;
    case (cmd)
      CMD_MERGE: begin
        if (!tables_built && in_range && node_cnt < MaxNodes - 1) begin
          ra = find_root(a);
          rb = find_root(b);
          node_cnt++;
          jump_tab[0][ra] = node_cnt;
          jump_tab[0][rb] = node_cnt;
          set_up[ra] = node_cnt;
          set_up[rb] = node_cnt;
          set_up[node_cnt] = node_cnt;
          ans.node = 10'(node_cnt);
          ans.status = STATUS_OK;
        end
      end
      CMD_BUILD: begin
        for (int i = node_cnt; i >= 1; i--) depth_of[i] = depth_of[jump_tab[0][i]] + 1;
        for (int k = 1; k < JumpLevels; k++)
          for (int i = 1; i <= node_cnt; i++) jump_tab[k][i] = jump_tab[k-1][jump_tab[k-1][i]];
        tables_built = 1'b1;
        ans.status = STATUS_OK;
      end
      CMD_QUERY: begin
        if (tables_built && in_range) begin
          ans.node = 10'(lowest_common(a, b));
          ans.status = STATUS_OK;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_left = hold_cycles;
      hold_cycles = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each result transfer against the oldest pending answer.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_answers.size() == 0) begin
        report($sformatf("unexpected result node=%0d status=%0b",
                         m_axis_tdata[9:0], m_axis_tuser));
      end else begin
        want = pending_answers.pop_front();
        if (m_axis_tdata[9:0] !== want.node)
          report($sformatf("result_node %0d, want %0d", m_axis_tdata[9:0], want.node));
        if (m_axis_tuser !== want.status)
          report($sformatf("status %0b, want %0b", m_axis_tuser, want.status));
      end
    end
  end

  // Offer one command, wait for its transfer, record the answer.
  task automatic send_cmd(cmd_e cmd, int a, int b, bit known = 0, int node = 0,
                          logic status = STATUS_OK);
    answer_t ans;
    if (items_sent < 350) send_idle_pct = 37;
    else if (items_sent < 700) send_idle_pct = 63;
    else send_idle_pct = 0;
    recv_stall_pct = (items_sent < 350) ? 63 : (items_sent < 700 ? 37 : 0);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0, b[9:0], a[9:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    ans = apply_command(cmd, a, b);
    if (known) begin
      ans.node = 10'(node);
      ans.status = status;
    end
    pending_answers = {pending_answers, ans};
    items_sent++;
  endtask

  // Pause the sender until every pending answer is in.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_leaves(int value);
    drain();
    repeat (80) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value[9:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    clear_model(value);
  endtask

  function automatic int pick_node(int pct_in_range);
    if ($urandom_range(99) < pct_in_range) return $urandom_range(node_cnt, 1);
    return $urandom_range(1023);
  endfunction

  // One well-formed tree: merges, build, queries, with some noise mixed in.
  task automatic tree_round(int leaves, int merges, int queries);
    int r;
    write_leaves(leaves);
    for (int i = 0; i < merges; i++) begin
      r = $urandom_range(99);
      if (r < 4) send_cmd(CMD_QUERY, pick_node(50), pick_node(50));
      else if (r < 7) send_cmd(CMD_NONE, pick_node(0), pick_node(0));
      else send_cmd(CMD_MERGE, pick_node(94), pick_node(94));
    end
    send_cmd(CMD_BUILD, $urandom_range(1023), $urandom_range(1023));
    for (int i = 0; i < queries; i++) begin
      r = $urandom_range(99);
      if (r < 4) send_cmd(CMD_MERGE, pick_node(80), pick_node(80));
      else if (r < 6) send_cmd(CMD_BUILD, pick_node(0), pick_node(0));
      else send_cmd(CMD_QUERY, pick_node(94), pick_node(94));
    end
  endtask

  dir_row_t dir_rows[18];

  initial begin
    clear_model(LeafReset);
    dir_rows = '{
      '{CMD_QUERY, 1, 2, 1, 0, STATUS_REJ},       // query before build
      '{CMD_MERGE, 0, 1, 1, 0, STATUS_REJ},       // node zero out of range
      '{CMD_MERGE, 1, 513, 1, 0, STATUS_REJ},     // just past the leaves
      '{CMD_MERGE, 1, 2, 1, 513, STATUS_OK},
      '{CMD_MERGE, 3, 512, 1, 514, STATUS_OK},
      '{CMD_MERGE, 513, 1, 1, 515, STATUS_OK},    // both in one tree already
      '{CMD_MERGE, 515, 514, 1, 516, STATUS_OK},
      '{CMD_NONE, 1023, 1023, 1, 0, STATUS_REJ},
      '{CMD_BUILD, 0, 0, 1, 0, STATUS_OK},
      '{CMD_MERGE, 5, 6, 1, 0, STATUS_REJ},       // merge after build
      '{CMD_QUERY, 1, 2, 0, 0, STATUS_OK},
      '{CMD_QUERY, 1, 3, 0, 0, STATUS_OK},
      '{CMD_QUERY, 2, 2, 0, 0, STATUS_OK},
      '{CMD_QUERY, 7, 8, 0, 0, STATUS_OK},        // separate trees
      '{CMD_QUERY, 1, 517, 1, 0, STATUS_REJ},
      '{CMD_QUERY, 1023, 1023, 1, 0, STATUS_REJ},
      '{CMD_BUILD, 1023, 1023, 1, 0, STATUS_OK},  // rebuild
      '{CMD_QUERY, 3, 516, 0, 0, STATUS_OK}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].cmd, dir_rows[i].a, dir_rows[i].b, dir_rows[i].known,
               dir_rows[i].node, dir_rows[i].status);

    // Leaf count extremes: zero counts as one, the top saturates to a full store.
    write_leaves(0);
    send_cmd(CMD_MERGE, 1, 1, 1, 2, STATUS_OK);
    send_cmd(CMD_MERGE, 2, 1, 1, 3, STATUS_OK);
    send_cmd(CMD_BUILD, 0, 0);
    send_cmd(CMD_QUERY, 1, 3);
    write_leaves(1023);
    send_cmd(CMD_MERGE, 1, 2, 1, 0, STATUS_REJ);
    send_cmd(CMD_MERGE, 1023, 1023, 1, 0, STATUS_REJ);
    write_leaves(1022);
    send_cmd(CMD_MERGE, 1022, 1, 1, 1023, STATUS_OK);
    send_cmd(CMD_MERGE, 1, 2, 1, 0, STATUS_REJ);
    send_cmd(CMD_BUILD, 0, 0);
    send_cmd(CMD_QUERY, 1023, 1022);
    send_cmd(CMD_QUERY, 1, 2);

    // Long output stall while commands keep coming in.
    write_leaves(16);
    hold_cycles = 400;
    for (int i = 0; i < 8; i++) send_cmd(CMD_MERGE, pick_node(100), pick_node(100));

    // Random trees, mostly small.
    while (items_sent < 1050) begin
      case ($urandom_range(9))
        0: tree_round($urandom_range(1023, 300), $urandom_range(40, 10), 20);
        1: tree_round($urandom_range(3, 1), 8, 12);
        default: tree_round($urandom_range(40, 2), $urandom_range(60, 5),
                            $urandom_range(50, 10));
      endcase
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
